// ----- rtl/cos_pkg.sv -----
// Shared widths, types and helpers for the color opponency salience core.
package cos_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 10;
  localparam int QUO_W      = 16;
  localparam int NUM_W      = PIX_W + QUO_W;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
  localparam int OPP_W      = 20;
  localparam int FRAC_SHIFT = 9;

  typedef logic        [PIX_W-1:0] pix_t;
  typedef logic        [SUM_W-1:0] sum_t;
  typedef logic        [QUO_W-1:0] quo_t;
  typedef logic        [NUM_W-1:0] num_t;
  typedef logic signed [OPP_W-1:0] opp_t;

  localparam pix_t THR_RESET = 8'd60;

  // Clamp a value in units of 1/512 to 0..255, truncating toward zero.
  function automatic pix_t clamp_out(opp_t v);
    logic [OPP_W-FRAC_SHIFT-1:0] q;
    q = v[OPP_W-1:FRAC_SHIFT];
    if (v[OPP_W-1] || (v == '0)) begin
      return '0;
    end else if (|q[OPP_W-FRAC_SHIFT-1:PIX_W]) begin
      return '1;
    end else begin
      return q[PIX_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/cos_divider.sv -----
// Pipelined restoring divider: quotient of a scaled channel by the channel sum.
module cos_divider (
  input  logic          clk,
  input  cos_pkg::num_t num,
  input  cos_pkg::sum_t den,
  output cos_pkg::quo_t quo
);
  import cos_pkg::*;

  sum_t rem_r [DIV_STAGES];
  quo_t low_r [DIV_STAGES];
  quo_t quo_r [DIV_STAGES];
  sum_t den_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    sum_t rem_src;
    quo_t low_src;
    quo_t quo_src;
    sum_t den_src;
    sum_t rem_next;
    quo_t low_next;
    quo_t quo_next;

    if (s == 0) begin : g_first
      // quotient fits in QUO_W bits, so the top bits start below the divisor
      assign rem_src = sum_t'(num[NUM_W-1:QUO_W]);
      assign low_src = num[QUO_W-1:0];
      assign quo_src = '0;
      assign den_src = den;
    end else begin : g_rest
      assign rem_src = rem_r[s-1];
      assign low_src = low_r[s-1];
      assign quo_src = quo_r[s-1];
      assign den_src = den_r[s-1];
    end

    always_comb begin : p_steps
      logic [SUM_W:0] ext;
      logic           bit_q;
      rem_next = rem_src;
      low_next = low_src;
      quo_next = quo_src;
      for (int i = 0; i < DIV_STEPS; i++) begin
        ext      = {rem_next, low_next[QUO_W-1]};
        low_next = {low_next[QUO_W-2:0], 1'b0};
        bit_q    = (ext >= {1'b0, den_src});
        if (bit_q) begin
          ext = ext - {1'b0, den_src};
        end
        rem_next = ext[SUM_W-1:0];
        quo_next = {quo_next[QUO_W-2:0], bit_q};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_next;
      low_r[s] <= low_next;
      quo_r[s] <= quo_next;
      den_r[s] <= den_src;
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ----- rtl/color_opponency_salience_core.sv -----
// Top level of the color opponency salience core.
//
// Usage:
//   Pixel channel: drive red_in, green_in, blue_in with start high; a pixel
//   transfers at each rising edge with start high and busy low. busy is low
//   at all times except during reset, so one pixel can enter every cycle.
//   Result channel: out_red, out_green, out_blue and saliency are valid for
//   exactly one cycle while done is high. The receiver cannot stall; results
//   leave in pixel order, one per accepted pixel.
//   Configuration: cfg_data transfers into dark_threshold when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write it only while no
//   pixel is in flight.
// Pipeline: a transferred pixel passes one input stage, four divider stages,
//   the opponency stage and the output stage before its result is accepted.
// Throughput: one pixel per cycle; the three normalizing divisions run in
//   parallel lanes, four quotient bits per divider stage.
// Reset: clears the pipeline valid bits and loads dark_threshold with 60;
//   no result is produced from a pixel held in the pipe at reset.
module color_opponency_salience_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cos_pkg::pix_t red_in,
  input  cos_pkg::pix_t green_in,
  input  cos_pkg::pix_t blue_in,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  cos_pkg::pix_t cfg_data,
  output logic          done,
  output cos_pkg::pix_t out_red,
  output cos_pkg::pix_t out_green,
  output cos_pkg::pix_t out_blue,
  output cos_pkg::pix_t saliency
);
  import cos_pkg::*;

  pix_t dark_threshold;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dark_threshold <= cfg_data;
    end
  end

  // Input stage: sum, dark test, yellow gate, scaled numerators
  sum_t sum_in;
  sum_t thr3;
  logic dark_in;
  logic ygate_in;

  assign sum_in   = sum_t'(red_in) + sum_t'(green_in) + sum_t'(blue_in);
  assign thr3     = {1'b0, dark_threshold, 1'b0} + sum_t'(dark_threshold);
  assign dark_in  = (sum_in == '0) || (sum_in < thr3);
  assign ygate_in = ({1'b0, red_in, 1'b0} > ({1'b0, blue_in, 1'b0} + sum_t'(blue_in)))
                 && ({1'b0, green_in, 1'b0} > ({1'b0, blue_in, 1'b0} + sum_t'(blue_in)));

  logic a_valid;
  logic a_dark;
  logic a_ygate;
  sum_t a_sum;
  num_t a_num_r;
  num_t a_num_g;
  num_t a_num_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
  end

  // 65280*c = (c << 16) - (c << 8)
  always_ff @(posedge clk) begin
    a_dark  <= dark_in;
    a_ygate <= ygate_in;
    a_sum   <= sum_in;
    a_num_r <= {red_in, 16'h0000} - {8'h00, red_in, 8'h00};
    a_num_g <= {green_in, 16'h0000} - {8'h00, green_in, 8'h00};
    a_num_b <= {blue_in, 16'h0000} - {8'h00, blue_in, 8'h00};
  end

  quo_t rn;
  quo_t gn;
  quo_t bn;

  cos_divider u_div_red   (.clk(clk), .num(a_num_r), .den(a_sum), .quo(rn));
  cos_divider u_div_green (.clk(clk), .num(a_num_g), .den(a_sum), .quo(gn));
  cos_divider u_div_blue  (.clk(clk), .num(a_num_b), .den(a_sum), .quo(bn));

  // Sideband flags travel alongside the divider lanes
  logic dly_valid [DIV_STAGES];
  logic dly_dark  [DIV_STAGES];
  logic dly_ygate [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        dly_valid[i] <= 1'b0;
      end
    end else begin
      dly_valid[0] <= a_valid;
      for (int i = 1; i < DIV_STAGES; i++) begin
        dly_valid[i] <= dly_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_dark[0]  <= a_dark;
    dly_ygate[0] <= a_ygate;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly_dark[i]  <= dly_dark[i-1];
      dly_ygate[i] <= dly_ygate[i-1];
    end
  end

  // Opponency stage, doubled values in units of 1/512
  opp_t rn_e;
  opp_t gn_e;
  opp_t bn_e;
  opp_t mn_e;

  assign rn_e = opp_t'(rn);
  assign gn_e = opp_t'(gn);
  assign bn_e = opp_t'(bn);
  assign mn_e = (rn < gn) ? rn_e : gn_e;

  logic b_valid;
  logic b_dark;
  opp_t b_ro;
  opp_t b_go;
  opp_t b_bo;
  opp_t b_yw;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= dly_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    b_dark <= dly_dark[DIV_STAGES-1];
    b_ro   <= (rn_e <<< 1) - gn_e - bn_e;
    b_go   <= (gn_e <<< 1) - rn_e - bn_e;
    b_bo   <= (bn_e <<< 1) - rn_e - gn_e;
    b_yw   <= dly_ygate[DIV_STAGES-1] ? ((mn_e <<< 2) - (bn_e <<< 1)) : '0;
  end

  // Output stage: max, clamp, force black on dark pixels
  opp_t max_rg;
  opp_t max_yb;
  opp_t max_all;

  assign max_rg  = (b_ro > b_go) ? b_ro : b_go;
  assign max_yb  = (b_yw > b_bo) ? b_yw : b_bo;
  assign max_all = (max_rg > max_yb) ? max_rg : max_yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_dark) begin
      out_red   <= '0;
      out_green <= '0;
      out_blue  <= '0;
      saliency  <= '0;
    end else begin
      out_red   <= clamp_out(b_ro);
      out_green <= clamp_out(b_go);
      out_blue  <= clamp_out(b_bo);
      saliency  <= clamp_out(max_all);
    end
  end

endmodule
